[design/ccv_pkg.sv]
// ccv_pkg: shared types and constants for the continued fraction convergent block
// no dependencies; used by ccv_mul and continued_fraction_convergents_top
package ccv_pkg;

  localparam int DATA_W = 64;

  typedef logic [DATA_W-1:0] word_t;

  // most positive signed word, also the "no bound" marker
  localparam word_t MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
  // magnitude of the most negative signed word
  localparam word_t MIN_MAG = {1'b1, {(DATA_W-1){1'b0}}};

  // status from the shared multiplier
  typedef struct packed {
    logic done;
    logic ov;
  } mul_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_H,
    S_WAIT_H,
    S_MUL_K,
    S_WAIT_K,
    S_SUM,
    S_MUL_LO,
    S_WAIT_LO,
    S_MUL_UP,
    S_WAIT_UP,
    S_OUT1,
    S_OUT2
  } state_t;

endpackage

[design/continued_fraction_convergents_top.sv]
// continued_fraction_convergents_top: convergents of a simple continued fraction
// sequencer, recurrence registers and output register; depends on ccv_pkg, ccv_mul
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  in      | in_valid / in_ready | term, final_term
//  out     | out_valid/out_ready | quotient, numerator, denominator, lower_bound,
//          |                     | upper_bound, bounds_valid, overflow, last
//
// every 64-bit product goes through one shared multiplier that works out one 32x32
// partial product per cycle, so the multiplier sets the pace: the first term of a
// fraction needs two products, every later term four products plus one add, plus
// any wait for a free output register
// in_ready is high only while the sequencer is idle; a finished item sits in
// the output register while the next term is accepted and worked on
// rst (synchronous) returns the recurrence to its start values and empties the output
module continued_fraction_convergents_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] term,
  input  logic        final_term,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] quotient,
  output logic [63:0] numerator,
  output logic [63:0] denominator,
  output logic [63:0] lower_bound,
  output logic [63:0] upper_bound,
  output logic        bounds_valid,
  output logic        overflow,
  output logic        last
);

  localparam int MSB = ccv_pkg::DATA_W - 1;

  ccv_pkg::state_t state;
  ccv_pkg::state_t state_next;

  // recurrence state
  ccv_pkg::word_t num_prev;
  ccv_pkg::word_t den_prev;
  ccv_pkg::word_t num_prev2;
  ccv_pkg::word_t den_prev2;
  ccv_pkg::word_t held_quotient;
  logic           have_first;
  logic           overflow_seen;

  // per-item working registers
  ccv_pkg::word_t term_held;
  logic           fin_held;
  ccv_pkg::word_t h_val;
  ccv_pkg::word_t k_val;
  ccv_pkg::word_t s_val;
  ccv_pkg::word_t lo_val;
  ccv_pkg::word_t up_val;
  logic           ov_run;

  // shared multiplier
  logic               mul_start;
  ccv_pkg::word_t     mul_a;
  ccv_pkg::word_t     mul_b;
  ccv_pkg::word_t     mul_prod;
  ccv_pkg::mul_stat_t mul_stat;

  // sequencer controls
  logic accept;
  logic ld_h;
  logic ld_k;
  logic ld_s;
  logic ld_lo;
  logic ld_up;
  logic push1;
  logic push2;
  logic commit;
  logic slot_free;

  // shared adder for the recurrence and the bound sum
  ccv_pkg::word_t add_x;
  ccv_pkg::word_t add_y;
  ccv_pkg::word_t add_r;
  logic           add_ov;

  ccv_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  // output register is free when empty or being drained this cycle
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ccv_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;

  // adder operands: h = prod + h2, k = prod + k2, s = k_prev + k
  always_comb begin
    add_x = mul_prod;
    add_y = num_prev2;
    case (state)
      ccv_pkg::S_WAIT_K: add_y = den_prev2;
      ccv_pkg::S_SUM: begin
        add_x = den_prev;
        add_y = k_val;
      end
      default: add_y = num_prev2;
    endcase
  end

  assign add_r  = add_x + add_y;
  // signed wrap: result sign differs from both operand signs
  assign add_ov = (add_x[MSB] ^ add_r[MSB]) & (add_y[MSB] ^ add_r[MSB]);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ccv_pkg::S_IDLE:    if (in_valid) state_next = ccv_pkg::S_MUL_H;
      ccv_pkg::S_MUL_H:   state_next = ccv_pkg::S_WAIT_H;
      ccv_pkg::S_WAIT_H:  if (mul_stat.done) state_next = ccv_pkg::S_MUL_K;
      ccv_pkg::S_MUL_K:   state_next = ccv_pkg::S_WAIT_K;
      ccv_pkg::S_WAIT_K: begin
        if (mul_stat.done) begin
          state_next = have_first ? ccv_pkg::S_SUM : ccv_pkg::S_OUT2;
        end
      end
      ccv_pkg::S_SUM:     state_next = ccv_pkg::S_MUL_LO;
      ccv_pkg::S_MUL_LO:  state_next = ccv_pkg::S_WAIT_LO;
      ccv_pkg::S_WAIT_LO: if (mul_stat.done) state_next = ccv_pkg::S_MUL_UP;
      ccv_pkg::S_MUL_UP:  state_next = ccv_pkg::S_WAIT_UP;
      ccv_pkg::S_WAIT_UP: if (mul_stat.done) state_next = ccv_pkg::S_OUT1;
      ccv_pkg::S_OUT1:    if (slot_free) state_next = ccv_pkg::S_OUT2;
      ccv_pkg::S_OUT2: begin
        if (!fin_held || slot_free) state_next = ccv_pkg::S_IDLE;
      end
      default:            state_next = ccv_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mul_start = 1'b0;
    mul_a     = term_held;
    mul_b     = num_prev;
    ld_h      = 1'b0;
    ld_k      = 1'b0;
    ld_s      = 1'b0;
    ld_lo     = 1'b0;
    ld_up     = 1'b0;
    push1     = 1'b0;
    push2     = 1'b0;
    commit    = 1'b0;
    case (state)
      ccv_pkg::S_MUL_H:   mul_start = 1'b1;
      ccv_pkg::S_WAIT_H:  ld_h = mul_stat.done;
      ccv_pkg::S_MUL_K: begin
        mul_start = 1'b1;
        mul_b     = den_prev;
      end
      ccv_pkg::S_WAIT_K:  ld_k = mul_stat.done;
      ccv_pkg::S_SUM:     ld_s = 1'b1;
      ccv_pkg::S_MUL_LO: begin
        mul_start = 1'b1;
        mul_a     = den_prev;
        mul_b     = s_val;
      end
      ccv_pkg::S_WAIT_LO: ld_lo = mul_stat.done;
      ccv_pkg::S_MUL_UP: begin
        mul_start = 1'b1;
        mul_a     = den_prev;
        mul_b     = k_val;
      end
      ccv_pkg::S_WAIT_UP: ld_up = mul_stat.done;
      ccv_pkg::S_OUT1:    push1 = slot_free;
      ccv_pkg::S_OUT2: begin
        push2  = fin_held && slot_free;
        commit = !fin_held || slot_free;
      end
      default:            mul_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccv_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      term_held <= term;
      fin_held  <= final_term;
      ov_run    <= overflow_seen;
    end
    if (ld_h) begin
      h_val  <= add_r;
      ov_run <= ov_run | mul_stat.ov | add_ov;
    end
    if (ld_k) begin
      k_val  <= add_r;
      ov_run <= ov_run | mul_stat.ov | add_ov;
    end
    if (ld_s) begin
      s_val  <= add_r;
      ov_run <= ov_run | add_ov;
    end
    if (ld_lo) begin
      lo_val <= mul_prod;
      ov_run <= ov_run | mul_stat.ov;
    end
    if (ld_up) begin
      up_val <= mul_prod;
      ov_run <= ov_run | mul_stat.ov;
    end
  end

  // recurrence state: shift on every term but the last, back to start values after the last
  always_ff @(posedge clk) begin
    if (rst || (commit && fin_held)) begin
      num_prev      <= ccv_pkg::DATA_W'(1);
      den_prev      <= '0;
      num_prev2     <= '0;
      den_prev2     <= ccv_pkg::DATA_W'(1);
      held_quotient <= '0;
      have_first    <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (commit) begin
      num_prev2     <= num_prev;
      den_prev2     <= den_prev;
      num_prev      <= h_val;
      den_prev      <= k_val;
      held_quotient <= term_held;
      have_first    <= 1'b1;
      overflow_seen <= ov_run;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push1 || push2) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push1) begin
      // previous term with its convergent and both bounds
      quotient     <= held_quotient;
      numerator    <= num_prev;
      denominator  <= den_prev;
      lower_bound  <= lo_val;
      upper_bound  <= up_val;
      bounds_valid <= 1'b1;
      overflow     <= ov_run;
      last         <= 1'b0;
    end else if (push2) begin
      // final convergent, bounds unbounded
      quotient     <= term_held;
      numerator    <= h_val;
      denominator  <= k_val;
      lower_bound  <= ccv_pkg::MAX_POS;
      upper_bound  <= ccv_pkg::MAX_POS;
      bounds_valid <= 1'b0;
      overflow     <= ov_run;
      last         <= 1'b1;
    end
  end

endmodule

[design/ccv_mul.sv]
// ccv_mul: iterative 64x64 signed wrapping multiplier with overflow detect
// one 32x32 partial product per cycle; depends on ccv_pkg
module ccv_mul (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ccv_pkg::word_t    op_a,
  input  ccv_pkg::word_t    op_b,
  output ccv_pkg::word_t    prod,
  output ccv_pkg::mul_stat_t stat
);

  localparam int HALF_W = ccv_pkg::DATA_W / 2;
  localparam int ACC_W  = 2 * ccv_pkg::DATA_W;

  ccv_pkg::word_t    ma;
  ccv_pkg::word_t    mb;
  logic              neg;
  logic [ACC_W-1:0]  acc;
  ccv_pkg::word_t    pp;
  logic [1:0]        pp_sh;
  logic              busy;
  logic [2:0]        cnt;
  logic              done;
  logic              wrapped;

  logic [HALF_W-1:0] a_half;
  logic [HALF_W-1:0] b_half;
  ccv_pkg::word_t    pp_w;
  logic [ACC_W-1:0]  pp_ext;
  ccv_pkg::word_t    lim;

  // partial product order: lo*lo, lo*hi, hi*lo, hi*hi
  assign a_half = cnt[1] ? ma[ccv_pkg::DATA_W-1:HALF_W] : ma[HALF_W-1:0];
  assign b_half = cnt[0] ? mb[ccv_pkg::DATA_W-1:HALF_W] : mb[HALF_W-1:0];
  assign pp_w   = ccv_pkg::DATA_W'(a_half) * ccv_pkg::DATA_W'(b_half);
  assign pp_ext = ACC_W'(pp) << (HALF_W * int'(pp_sh));
  assign lim    = neg ? ccv_pkg::MIN_MAG : ccv_pkg::MAX_POS;

  // status fields: done first, then overflow
  assign stat = {done, wrapped};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= op_a[ccv_pkg::DATA_W-1] ? (~op_a + 1'b1) : op_a;
      mb  <= op_b[ccv_pkg::DATA_W-1] ? (~op_b + 1'b1) : op_b;
      neg <= op_a[ccv_pkg::DATA_W-1] ^ op_b[ccv_pkg::DATA_W-1];
      acc <= '0;
    end else if (busy) begin
      if (!cnt[2]) begin
        pp    <= pp_w;
        pp_sh <= 2'(cnt[1]) + 2'(cnt[0]);
      end
      if (cnt != 3'd0 && cnt != 3'd5) begin
        acc <= acc + pp_ext;
      end
      if (cnt == 3'd5) begin
        prod    <= neg ? (~acc[ccv_pkg::DATA_W-1:0] + 1'b1) : acc[ccv_pkg::DATA_W-1:0];
        wrapped <= (|acc[ACC_W-1:ccv_pkg::DATA_W]) || (acc[ccv_pkg::DATA_W-1:0] > lim);
      end
    end
  end

endmodule
